// ----- src/direct_sound_fifo_mixer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Direct sound FIFO mixer assertion macros
// Shorthand for clocked implication checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef DIRECT_SOUND_FIFO_MIXER_UNIT_ASSERT_SVH
`define DIRECT_SOUND_FIFO_MIXER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DSFM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DSFM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dsfm_pkg.sv -----
// ----------------------------------------------------------------------------
// dsfm_pkg
// Shared constants, codes and helpers of the direct sound FIFO mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsfm_pkg;

    // FIFO geometry (valid range 4..16 words)
    localparam int FIFO_WORDS = 8;
    localparam int PTR_W      = $clog2(FIFO_WORDS);
    localparam int FILL_W     = $clog2(FIFO_WORDS + 1);
    localparam int SUM_W      = $clog2(2 * FIFO_WORDS);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_WORDS);
    localparam logic [FILL_W-1:0] LOW_WATER = FILL_W'(3);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_WORDS - 1);
    localparam logic [SUM_W-1:0]  SUM_WRAP  = SUM_W'(FIFO_WORDS);

    // Byte pipe
    localparam logic [2:0] PIPE_BYTES = 3'd4;

    // Mixer constants
    localparam logic [9:0] BIAS_RESET = 10'h200;
    localparam logic [9:0] CLAMP_MAX  = 10'h3FF;
    localparam logic [9:0] AUDIO_MID  = 10'h200;

    // Tone volume codes
    localparam logic [1:0] PSG_VOL_X1   = 2'd0;
    localparam logic [1:0] PSG_VOL_X2   = 2'd1;
    localparam logic [1:0] PSG_VOL_X4   = 2'd2;
    localparam logic [1:0] PSG_VOL_MUTE = 2'd3;

    // Port layout
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam int OUT_DMA_A_BIT = 0;
    localparam int OUT_DMA_B_BIT = 1;
    localparam int OUT_LEFT_LSB  = 2;
    localparam int OUT_RIGHT_MSB = 21;
    localparam int OUT_MIX_BIT   = 0;

    typedef enum logic [1:0] {
        CMD_FIFO_WRITE = 2'd0,
        CMD_TIMER      = 2'd1,
        CMD_MIX        = 2'd2
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MASTER_ENABLE    = 3'd0,
        REG_PSG_VOLUME       = 3'd1,
        REG_PSG_MASTER_LEFT  = 3'd2,
        REG_PSG_MASTER_RIGHT = 3'd3,
        REG_PSG_ENABLE_MASK  = 3'd4,
        REG_FIFO_CONTROL     = 3'd5,
        REG_BIAS_LEVEL       = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Tone gain x1 / x2 / x4 / mute, as shifts
    function automatic logic signed [11:0] psg_scale(input logic signed [9:0] s,
                                                     input logic [1:0] vol);
        logic signed [11:0] r;
        unique case (vol)
            PSG_VOL_X1:   r = {{2{s[9]}}, s};
            PSG_VOL_X2:   r = {s[9], s, 1'b0};
            PSG_VOL_X4:   r = {s, 2'b00};
            PSG_VOL_MUTE: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/direct_sound_fifo_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// direct_sound_fifo_mixer_unit
// Two direct sound sample FIFOs with refill pipes and a stereo tone mixer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per command. s_tuser carries the command
//   and FIFO select, s_tdata the FIFO word, timer number and four tone samples.
//   Output stream (m_*): exactly one result per request, in order. m_tuser is
//   the mix flag, m_tdata the two DMA request bits and the stereo sample.
//   Config port: cfg_we writes cfg_wdata to register cfg_addr;
//   write only while no request is in flight.
// Timing:
//   A request is taken in the idle state; the FIFO memories are read at that
//   edge and the update and result are formed in the execute state, which
//   holds while the output register is full. No new request is taken before
//   the result is registered, due to the two-step synchronous memory read.
// Reset:
//   Config registers, fill counts, pointers, pipes and latches clear (bias
//   returns to 512). FIFO memory contents are not cleared; no sweep is needed.
// Stall:
//   A result waits in the output register; one more request is taken
//   meanwhile and then holds in its execute state until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module direct_sound_fifo_mixer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write port
    input  logic                               cfg_we,
    input  logic [dsfm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [dsfm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fifo_word[31:0], timer_number[33:32], tone1[41:34], tone2[49:42],
    // tone3[57:50], tone4[65:58], zero pad above
    input  logic [dsfm_pkg::S_TDATA_W-1:0]     s_tdata,
    // command[1:0], fifo_select[2]
    input  logic [dsfm_pkg::S_TUSER_W-1:0]     s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // dma_request_a[0], dma_request_b[1], left_out[11:2], right_out[21:12],
    // zero pad above
    output logic [dsfm_pkg::M_TDATA_W-1:0]     m_tdata,
    // mix_valid[0]
    output logic [dsfm_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int PTR_W  = dsfm_pkg::PTR_W;
    localparam int FILL_W = dsfm_pkg::FILL_W;
    localparam int SUM_W  = dsfm_pkg::SUM_W;

    // ---------------- config registers ----------------
    logic       master_enable_reg;
    logic [1:0] psg_volume_reg;
    logic [2:0] psg_master_left_reg;
    logic [2:0] psg_master_right_reg;
    logic [7:0] psg_enable_mask_reg;
    logic [7:0] fifo_control_reg;
    logic [9:0] bias_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_enable_reg    <= 1'b0;
            psg_volume_reg       <= '0;
            psg_master_left_reg  <= '0;
            psg_master_right_reg <= '0;
            psg_enable_mask_reg  <= '0;
            fifo_control_reg     <= '0;
            bias_level_reg       <= dsfm_pkg::BIAS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                dsfm_pkg::REG_MASTER_ENABLE:    master_enable_reg    <= cfg_wdata[0];
                dsfm_pkg::REG_PSG_VOLUME:       psg_volume_reg       <= cfg_wdata[1:0];
                dsfm_pkg::REG_PSG_MASTER_LEFT:  psg_master_left_reg  <= cfg_wdata[2:0];
                dsfm_pkg::REG_PSG_MASTER_RIGHT: psg_master_right_reg <= cfg_wdata[2:0];
                dsfm_pkg::REG_PSG_ENABLE_MASK:  psg_enable_mask_reg  <= cfg_wdata[7:0];
                dsfm_pkg::REG_FIFO_CONTROL:     fifo_control_reg     <= cfg_wdata[7:0];
                dsfm_pkg::REG_BIAS_LEVEL:       bias_level_reg       <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    dsfm_pkg::state_t state_reg, state_next;
    logic accept;
    logic exec_go;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsfm_pkg::ST_IDLE: if (accept)  state_next = dsfm_pkg::ST_EXEC;
            dsfm_pkg::ST_EXEC: if (exec_go) state_next = dsfm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        exec_go  = 1'b0;
        unique case (state_reg)
            dsfm_pkg::ST_IDLE: s_tready = 1'b1;
            dsfm_pkg::ST_EXEC: exec_go  = !m_tvalid || m_tready;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsfm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- request registers ----------------
    logic [1:0]       item_cmd_reg;
    logic             item_sel_reg;
    logic [31:0]      item_word_reg;
    logic [1:0]       item_timer_reg;
    logic [3:0][7:0]  item_tones_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_cmd_reg   <= s_tuser[1:0];
            item_sel_reg   <= s_tuser[2];
            item_word_reg  <= s_tdata[31:0];
            item_timer_reg <= s_tdata[33:32];
            item_tones_reg <= s_tdata[65:34];
        end
    end

    // ---------------- FIFO state ----------------
    logic [FILL_W-1:0] fifo_fill_reg  [2];
    logic [FILL_W-1:0] fifo_fill_next [2];
    logic [PTR_W-1:0]  rd_ptr_reg     [2];
    logic [PTR_W-1:0]  rd_ptr_next    [2];
    logic [31:0]       pipe_word_reg  [2];
    logic [31:0]       pipe_word_next [2];
    logic [2:0]        pipe_count_reg [2];
    logic [2:0]        pipe_count_next[2];
    logic [7:0]        latch_reg      [2];
    logic [7:0]        latch_next     [2];
    logic [1:0]        dma_req;
    logic [1:0]        mem_we;
    logic [PTR_W-1:0]  wr_addr;

    // sample memories, one per FIFO so both can be read in the same cycle
    logic [31:0] fifo_mem_a [dsfm_pkg::FIFO_WORDS];
    logic [31:0] fifo_mem_b [dsfm_pkg::FIFO_WORDS];
    logic [31:0] rdata_reg  [2];

    always_ff @(posedge aclk) begin
        if (mem_we[0]) begin
            fifo_mem_a[wr_addr] <= item_word_reg;
        end
        if (mem_we[1]) begin
            fifo_mem_b[wr_addr] <= item_word_reg;
        end
        // head words fetched on acceptance, used in the execute cycle
        if (accept) begin
            rdata_reg[0] <= fifo_mem_a[rd_ptr_reg[0]];
            rdata_reg[1] <= fifo_mem_b[rd_ptr_reg[1]];
        end
    end

    // tail address of the selected FIFO: (head + fill) mod depth
    logic [FILL_W-1:0] sel_fill;
    logic [SUM_W-1:0]  wr_sum;

    always_comb begin
        sel_fill = item_sel_reg ? fifo_fill_reg[1] : fifo_fill_reg[0];
        wr_sum   = SUM_W'(item_sel_reg ? rd_ptr_reg[1] : rd_ptr_reg[0]) + SUM_W'(sel_fill);
        if (wr_sum >= dsfm_pkg::SUM_WRAP) begin
            wr_addr = PTR_W'(wr_sum - dsfm_pkg::SUM_WRAP);
        end else begin
            wr_addr = PTR_W'(wr_sum);
        end
    end

    always_comb begin
        logic        served;
        logic        refill;
        logic [31:0] word;
        logic [2:0]  count;
        for (int f = 0; f < 2; f++) begin
            fifo_fill_next[f]  = fifo_fill_reg[f];
            rd_ptr_next[f]     = rd_ptr_reg[f];
            pipe_word_next[f]  = pipe_word_reg[f];
            pipe_count_next[f] = pipe_count_reg[f];
            latch_next[f]      = latch_reg[f];
            dma_req[f]         = 1'b0;
            mem_we[f]          = 1'b0;

            if (exec_go && item_cmd_reg == dsfm_pkg::CMD_FIFO_WRITE
                    && item_sel_reg == f[0] && fifo_fill_reg[f] < dsfm_pkg::FILL_FULL) begin
                mem_we[f]         = 1'b1;
                fifo_fill_next[f] = fifo_fill_reg[f] + 1'b1;
            end

            served = exec_go && item_cmd_reg == dsfm_pkg::CMD_TIMER && master_enable_reg
                     && {1'b0, fifo_control_reg[4*f+3]} == item_timer_reg;
            refill = pipe_count_reg[f] == '0 && fifo_fill_reg[f] != '0;
            word   = refill ? rdata_reg[f] : pipe_word_reg[f];
            count  = refill ? dsfm_pkg::PIPE_BYTES : pipe_count_reg[f];

            if (served) begin
                dma_req[f] = fifo_fill_reg[f] <= dsfm_pkg::LOW_WATER;
                if (refill) begin
                    fifo_fill_next[f] = fifo_fill_reg[f] - 1'b1;
                    rd_ptr_next[f]    = (rd_ptr_reg[f] == dsfm_pkg::PTR_LAST)
                                        ? '0 : rd_ptr_reg[f] + 1'b1;
                end
                if (count != '0) begin
                    latch_next[f]      = word[7:0];
                    pipe_word_next[f]  = {8'h00, word[31:8]};
                    pipe_count_next[f] = count - 1'b1;
                end else begin
                    latch_next[f] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int f = 0; f < 2; f++) begin
            if (!aresetn) begin
                fifo_fill_reg[f]  <= '0;
                rd_ptr_reg[f]     <= '0;
                pipe_word_reg[f]  <= '0;
                pipe_count_reg[f] <= '0;
                latch_reg[f]      <= '0;
            end else begin
                fifo_fill_reg[f]  <= fifo_fill_next[f];
                rd_ptr_reg[f]     <= rd_ptr_next[f];
                pipe_word_reg[f]  <= pipe_word_next[f];
                pipe_count_reg[f] <= pipe_count_next[f];
                latch_reg[f]      <= latch_next[f];
            end
        end
    end

    // ---------------- mixer ----------------
    function automatic logic [9:0] mix_channel(
        input logic [3:0]      tone_en,
        input logic [2:0]      master,
        input logic [1:0]      vol,
        input logic [3:0][7:0] tones,
        input logic [1:0]      ds_en,
        input logic [1:0]      ds_x4,
        input logic [7:0]      lat0,
        input logic [7:0]      lat1,
        input logic [9:0]      bias
    );
        logic signed [9:0]  psg_sum;
        logic signed [11:0] psg_scaled;
        logic signed [4:0]  master_gain;
        logic signed [16:0] psg_prod;
        logic signed [12:0] acc;
        logic [9:0]         clamped;
        psg_sum = '0;
        for (int t = 0; t < 4; t++) begin
            if (tone_en[t]) begin
                psg_sum = psg_sum + {{2{tones[t][7]}}, tones[t]};
            end
        end
        psg_scaled  = dsfm_pkg::psg_scale(psg_sum, vol);
        master_gain = 5'({2'b00, master}) + 5'sd1;
        psg_prod    = psg_scaled * master_gain;
        // floor divide by 32
        acc = {psg_prod[16], psg_prod[16:5]};
        if (ds_en[0]) begin
            acc = acc + (ds_x4[0] ? {{3{lat0[7]}}, lat0, 2'b00} : {{4{lat0[7]}}, lat0, 1'b0});
        end
        if (ds_en[1]) begin
            acc = acc + (ds_x4[1] ? {{3{lat1[7]}}, lat1, 2'b00} : {{4{lat1[7]}}, lat1, 1'b0});
        end
        acc = acc + {3'b000, bias};
        if (acc[12]) begin
            clamped = '0;
        end else if (acc[11:10] != 2'b00) begin
            clamped = dsfm_pkg::CLAMP_MAX;
        end else begin
            clamped = acc[9:0];
        end
        return clamped - dsfm_pkg::AUDIO_MID;
    endfunction

    logic [9:0] left_mix;
    logic [9:0] right_mix;

    always_comb begin
        left_mix  = mix_channel(psg_enable_mask_reg[3:0], psg_master_left_reg, psg_volume_reg,
                                item_tones_reg, {fifo_control_reg[5], fifo_control_reg[1]},
                                {fifo_control_reg[4], fifo_control_reg[0]},
                                latch_reg[0], latch_reg[1], bias_level_reg);
        right_mix = mix_channel(psg_enable_mask_reg[7:4], psg_master_right_reg, psg_volume_reg,
                                item_tones_reg, {fifo_control_reg[6], fifo_control_reg[2]},
                                {fifo_control_reg[4], fifo_control_reg[0]},
                                latch_reg[0], latch_reg[1], bias_level_reg);
    end

    // ---------------- result register ----------------
    logic                              out_valid_reg;
    logic [dsfm_pkg::M_TDATA_W-1:0]    out_tdata_reg;
    logic [dsfm_pkg::M_TDATA_W-1:0]    out_tdata_next;
    logic                              out_mix_reg;
    logic                              out_mix_next;

    always_comb begin
        out_tdata_next = '0;
        out_mix_next   = 1'b0;
        unique case (item_cmd_reg)
            dsfm_pkg::CMD_TIMER: begin
                out_tdata_next[dsfm_pkg::OUT_DMA_A_BIT] = dma_req[0];
                out_tdata_next[dsfm_pkg::OUT_DMA_B_BIT] = dma_req[1];
            end
            dsfm_pkg::CMD_MIX: begin
                out_mix_next = 1'b1;
                if (master_enable_reg) begin
                    out_tdata_next[dsfm_pkg::OUT_RIGHT_MSB:dsfm_pkg::OUT_LEFT_LSB] =
                        {right_mix, left_mix};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go) begin
            out_tdata_reg <= out_tdata_next;
            out_mix_reg   <= out_mix_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_mix_reg;

endmodule

// ----- src/dsfm_checker.sv -----
// ----------------------------------------------------------------------------
// dsfm_checker
// Port-level checks of the direct sound FIFO mixer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "direct_sound_fifo_mixer_unit_assert.svh"

module dsfm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dsfm_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [dsfm_pkg::M_TUSER_W-1:0]  m_tuser
);

    // a stalled result holds
    `DSFM_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // one request in flight: the cycle after acceptance is busy
    `DSFM_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken in execute cycle")

    // mix results never carry refill requests
    `DSFM_ASSERT_IMP(a_mix_no_dma, aclk, aresetn, m_tvalid && m_tuser[dsfm_pkg::OUT_MIX_BIT], m_tdata[dsfm_pkg::OUT_DMA_B_BIT:dsfm_pkg::OUT_DMA_A_BIT] == 2'b00, "DMA request on a mix result")

    // non-mix results carry silent audio fields
    `DSFM_ASSERT_IMP(a_nonmix_quiet, aclk, aresetn, m_tvalid && !m_tuser[dsfm_pkg::OUT_MIX_BIT], m_tdata[dsfm_pkg::OUT_RIGHT_MSB:dsfm_pkg::OUT_LEFT_LSB] == '0, "audio on a non-mix result")

endmodule

bind direct_sound_fifo_mixer_unit dsfm_checker u_dsfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/mixer_output_check.sv -----
// ----------------------------------------------------------------------------
// mixer_output_check
// Follows the config port and both streams of the direct sound FIFO mixer,
// keeps its own copy of the FIFOs, pipes, latches and registers, works out
// the result owed for every accepted request and compares it field by field
// with each accepted result, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mixer_output_check (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [dsfm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dsfm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [dsfm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [dsfm_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [dsfm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [dsfm_pkg::M_TUSER_W-1:0]    m_tuser,
    output int                                mismatch_count,
    output int                                owed_count
);

    typedef struct packed {
        logic       dma_a;
        logic       dma_b;
        logic       mix;
        logic [9:0] left;
        logic [9:0] right;
    } mixer_out_t;

    // register copies
    logic       master_on;
    logic [1:0] psg_vol;
    logic [2:0] psg_left;
    logic [2:0] psg_right;
    logic [7:0] psg_mask;
    logic [7:0] fifo_ctrl;
    logic [9:0] bias;

    // FIFO and pipe state, index 0 = A, 1 = B
    logic [31:0]       fifo_words [2][dsfm_pkg::FIFO_WORDS];
    int                fifo_fill [2];
    int                fifo_rd [2];
    logic [31:0]       pipe_word [2];
    int                pipe_left [2];
    logic signed [7:0] dsound_latch [2];

    mixer_out_t owed_outputs [$];
    int         errors = 0;

    // Returns the refill request; advances the pipe and the sample latch.
    function automatic logic serve_sample_fifo(int f);
        logic low;
        low = (fifo_fill[f] <= int'(dsfm_pkg::LOW_WATER));
        if (pipe_left[f] == 0 && fifo_fill[f] > 0) begin
            pipe_word[f] = fifo_words[f][fifo_rd[f]];
            fifo_rd[f]   = (fifo_rd[f] + 1) % dsfm_pkg::FIFO_WORDS;
            fifo_fill[f]--;
            pipe_left[f] = int'(dsfm_pkg::PIPE_BYTES);
        end
        if (pipe_left[f] > 0) begin
            dsound_latch[f] = pipe_word[f][7:0];
            pipe_word[f]    = pipe_word[f] >> 8;
            pipe_left[f]--;
        end else begin
            dsound_latch[f] = '0;
        end
        return low;
    endfunction

    // tones: tone1 in [7:0] up to tone4 in [31:24]
    function automatic logic [9:0] mix_side(int side, logic [31:0] tones);
        int         tone_sum;
        int         gain;
        int         acc;
        logic [3:0] nib;
        tone_sum = 0;
        for (int t = 0; t < 4; t++)
            if (psg_mask[side*4 + t])
                tone_sum += $signed(tones[t*8 +: 8]);
        unique case (psg_vol)
            dsfm_pkg::PSG_VOL_X1: gain = 1;
            dsfm_pkg::PSG_VOL_X2: gain = 2;
            dsfm_pkg::PSG_VOL_X4: gain = 4;
            default:              gain = 0;
        endcase
        // arithmetic shift gives the floor of the division by 32
        acc = (tone_sum * gain * (int'(side ? psg_right : psg_left) + 1)) >>> 5;
        for (int f = 0; f < 2; f++) begin
            nib = fifo_ctrl[f*4 +: 4];
            if (nib[1 + side])
                acc += dsound_latch[f] * (nib[0] ? 4 : 2);
        end
        acc += int'(bias);
        if (acc < 0)
            acc = 0;
        if (acc > int'(dsfm_pkg::CLAMP_MAX))
            acc = int'(dsfm_pkg::CLAMP_MAX);
        return 10'(acc - int'(dsfm_pkg::AUDIO_MID));
    endfunction

    function automatic mixer_out_t predict_output(logic [1:0] cmd, logic sel,
                                                  logic [31:0] word, logic [1:0] timer,
                                                  logic [31:0] tones);
        mixer_out_t r;
        r = '0;
        unique case (cmd)
            dsfm_pkg::CMD_FIFO_WRITE: begin
                // a push to a full FIFO is dropped
                if (fifo_fill[sel] < dsfm_pkg::FIFO_WORDS) begin
                    fifo_words[sel][(fifo_rd[sel] + fifo_fill[sel]) % dsfm_pkg::FIFO_WORDS]
                        = word;
                    fifo_fill[sel]++;
                end
            end
            dsfm_pkg::CMD_TIMER: begin
                if (master_on) begin
                    if (timer == {1'b0, fifo_ctrl[3]})
                        r.dma_a = serve_sample_fifo(0);
                    if (timer == {1'b0, fifo_ctrl[7]})
                        r.dma_b = serve_sample_fifo(1);
                end
            end
            dsfm_pkg::CMD_MIX: begin
                r.mix = 1'b1;
                if (master_on) begin
                    r.left  = mix_side(0, tones);
                    r.right = mix_side(1, tones);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_bad(string what, mixer_out_t want, mixer_out_t got,
                            logic [1:0] pad);
        errors++;
        if (errors <= 10) begin
            $write("%0t %s: exp dma_a=%0b dma_b=%0b mix=%0b left=%0d right=%0d",
                   $realtime, what, want.dma_a, want.dma_b, want.mix,
                   $signed(want.left), $signed(want.right));
            $display(" | got dma_a=%0b dma_b=%0b mix=%0b left=%0d right=%0d pad=%0b",
                     got.dma_a, got.dma_b, got.mix, $signed(got.left),
                     $signed(got.right), pad);
        end
    endtask

    always @(posedge aclk) begin : follow
        mixer_out_t want;
        mixer_out_t got;
        if (!aresetn) begin
            master_on = 1'b0;
            psg_vol   = '0;
            psg_left  = '0;
            psg_right = '0;
            psg_mask  = '0;
            fifo_ctrl = '0;
            bias      = dsfm_pkg::BIAS_RESET;
            for (int f = 0; f < 2; f++) begin
                fifo_fill[f]    = 0;
                fifo_rd[f]      = 0;
                pipe_word[f]    = '0;
                pipe_left[f]    = 0;
                dsound_latch[f] = '0;
            end
            owed_outputs.delete();
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    dsfm_pkg::REG_MASTER_ENABLE:    master_on = cfg_wdata[0];
                    dsfm_pkg::REG_PSG_VOLUME:       psg_vol   = cfg_wdata[1:0];
                    dsfm_pkg::REG_PSG_MASTER_LEFT:  psg_left  = cfg_wdata[2:0];
                    dsfm_pkg::REG_PSG_MASTER_RIGHT: psg_right = cfg_wdata[2:0];
                    dsfm_pkg::REG_PSG_ENABLE_MASK:  psg_mask  = cfg_wdata[7:0];
                    dsfm_pkg::REG_FIFO_CONTROL:     fifo_ctrl = cfg_wdata[7:0];
                    dsfm_pkg::REG_BIAS_LEVEL:       bias      = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                owed_outputs.push_back(predict_output(s_tuser[1:0], s_tuser[2],
                                                      s_tdata[31:0], s_tdata[33:32],
                                                      s_tdata[65:34]));
            if (m_tvalid && m_tready) begin
                got.dma_a = m_tdata[dsfm_pkg::OUT_DMA_A_BIT];
                got.dma_b = m_tdata[dsfm_pkg::OUT_DMA_B_BIT];
                got.mix   = m_tuser[dsfm_pkg::OUT_MIX_BIT];
                got.left  = m_tdata[11:2];
                got.right = m_tdata[21:12];
                if (owed_outputs.size() == 0) begin
                    flag_bad("result with nothing owed", '0, got, m_tdata[23:22]);
                end else begin
                    want = owed_outputs.pop_front();
                    if (got.dma_a !== want.dma_a || got.dma_b !== want.dma_b ||
                        got.mix !== want.mix || got.left !== want.left ||
                        got.right !== want.right || m_tdata[23:22] !== 2'b00)
                        flag_bad("result mismatch", want, got, m_tdata[23:22]);
                end
            end
        end
        owed_count     <= owed_outputs.size();
        mismatch_count <= errors;
    end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the direct sound FIFO mixer with a directed opening and random
// phases of pushes, timer overflows and mixes under several register
// settings, with random gaps on both streams, one long result stall and
// drain pauses. Checking is done by mixer_output_check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         LONG_HOLD      = 150;
    localparam int         PHASES         = 7;
    localparam int         PHASE_ITEMS    = 120;
    localparam int         PRESSURE_ITEMS = 30;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [dsfm_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [dsfm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    // fifo_word[31:0], timer_number[33:32], tone1..tone4[65:34], zero pad
    logic [dsfm_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    // command[1:0], fifo_select[2]
    logic [dsfm_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // dma_request_a[0], dma_request_b[1], left_out[11:2], right_out[21:12], zero pad
    logic [dsfm_pkg::M_TDATA_W-1:0]  m_tdata;
    // mix_valid[0]
    logic [dsfm_pkg::M_TUSER_W-1:0]  m_tuser;

    int         mismatch_count;
    int         owed_count;
    logic [7:0] fifo_ctrl_now = '0;
    bit         hold_off_req  = 1'b0;
    bit         holding       = 1'b0;
    int         steady_left   = 0;

    always #1 aclk = ~aclk;

    direct_sound_fifo_mixer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    mixer_output_check mix_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .owed_count     (owed_count)
    );

    task automatic write_reg(dsfm_pkg::cfg_reg_t idx,
                             logic [dsfm_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic apply_settings(logic master, logic [1:0] vol, logic [2:0] left,
                                  logic [2:0] right, logic [7:0] mask,
                                  logic [7:0] ctrl, logic [9:0] bias);
        write_reg(dsfm_pkg::REG_MASTER_ENABLE,    dsfm_pkg::CFG_DATA_W'(master));
        write_reg(dsfm_pkg::REG_PSG_VOLUME,       dsfm_pkg::CFG_DATA_W'(vol));
        write_reg(dsfm_pkg::REG_PSG_MASTER_LEFT,  dsfm_pkg::CFG_DATA_W'(left));
        write_reg(dsfm_pkg::REG_PSG_MASTER_RIGHT, dsfm_pkg::CFG_DATA_W'(right));
        write_reg(dsfm_pkg::REG_PSG_ENABLE_MASK,  dsfm_pkg::CFG_DATA_W'(mask));
        write_reg(dsfm_pkg::REG_FIFO_CONTROL,     dsfm_pkg::CFG_DATA_W'(ctrl));
        write_reg(dsfm_pkg::REG_BIAS_LEVEL,       bias);
        cfg_we        <= 1'b0;
        fifo_ctrl_now  = ctrl;
    endtask

    // tones: tone1 in [7:0] up to tone4 in [31:24]
    task automatic send_req(logic [1:0] cmd, logic sel, logic [31:0] word,
                            logic [1:0] timer, logic [31:0] tones, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, cmd};
        s_tdata  <= {6'd0, tones, timer, word};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pick_gap(output int gap);
        int r;
        r = $urandom_range(0, 99);
        if (steady_left > 0) begin
            steady_left--;
            gap = 0;
        end else if (r < 8) begin
            steady_left = $urandom_range(20, 50);
            gap = 0;
        end else if (r < 60) begin
            gap = 0;
        end else if (r < 93) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 25);
        end
    endtask

    // Mostly pushes and timers aimed at a bound FIFO; some noise.
    task automatic random_item(int push_pct, bit eager);
        logic [1:0] cmd;
        logic [1:0] timer;
        logic       sel;
        int         r;
        int         f;
        int         gap;
        timer = 2'($urandom_range(0, 3));
        sel   = 1'($urandom_range(0, 1));
        r     = $urandom_range(0, 99);
        if (r < push_pct) begin
            cmd = dsfm_pkg::CMD_FIFO_WRITE;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                cmd   = dsfm_pkg::CMD_TIMER;
                f     = $urandom_range(0, 1);
                timer = {1'b0, fifo_ctrl_now[f*4 + 3]};
            end else if (r < 85) begin
                cmd = dsfm_pkg::CMD_MIX;
            end else if (r < 95) begin
                cmd = dsfm_pkg::CMD_TIMER;
            end else begin
                cmd = CMD_UNUSED;
            end
        end
        gap = 0;
        if (!eager)
            pick_gap(gap);
        send_req(cmd, sel, $urandom, timer, $urandom, gap);
    endtask

    // Lowers valid, then waits out every owed result plus the block latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_count != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // result side ready pattern, with one long hold on request
    initial begin : result_sink
        int n;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                holding   = 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
                holding      = 1'b0;
                hold_off_req = 1'b0;
            end else begin
                m_tready <= 1'b1;
                n = ($urandom_range(0, 99) < 20) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 6);
                repeat (n) @(posedge aclk);
                m_tready <= 1'b0;
                n = ($urandom_range(0, 99) < 15) ? $urandom_range(8, 30)
                                                 : $urandom_range(1, 3);
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int push_pct;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: master off, so timers do nothing and mixes are zero
        send_req(dsfm_pkg::CMD_TIMER, 1'b0, 32'h0, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_MIX, 1'b0, 32'h0, 2'd0, 32'h80808080, 0);
        send_req(CMD_UNUSED, 1'b1, 32'hFFFFFFFF, 2'd3, 32'hFFFFFFFF, 1);
        drain();

        // A on timer 0 at x4, B on timer 1 at x2, both on both sides
        apply_settings(1'b1, dsfm_pkg::PSG_VOL_X4, 3'd7, 3'd7, 8'hFF, 8'hE7, 10'h3FF);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'h7F8001FF, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'h00000000, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'hFFFFFFFF, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'h80808080, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'h7F7F7F7F, 2'd0, 32'h0, 2);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'h123456F0, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'hA5A55A5A, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'h01020304, 2'd0, 32'h0, 0);
        // FIFO A is full here: this word is dropped
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b0, 32'hDEADBEEF, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_FIFO_WRITE, 1'b1, 32'h807F01FF, 2'd0, 32'h0, 0);
        repeat (4) send_req(dsfm_pkg::CMD_TIMER, 1'b0, 32'h0, 2'd0, 32'h0, 0);
        send_req(dsfm_pkg::CMD_TIMER, 1'b0, 32'h0, 2'd1, 32'h0, 0);
        // timers that no FIFO can be bound to
        send_req(dsfm_pkg::CMD_TIMER, 1'b0, 32'h0, 2'd2, 32'h0, 0);
        send_req(dsfm_pkg::CMD_TIMER, 1'b0, 32'h0, 2'd3, 32'h0, 3);
        send_req(dsfm_pkg::CMD_MIX, 1'b0, 32'h0, 2'd0, 32'h7F7F7F7F, 0);
        send_req(dsfm_pkg::CMD_MIX, 1'b0, 32'h0, 2'd0, 32'h80808080, 0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            unique case (phase)
                0: apply_settings(1'b1, dsfm_pkg::PSG_VOL_MUTE, 3'd7, 3'd7, 8'hFF, 8'hFF,
                                  10'h3FF);
                1: apply_settings(1'b0, dsfm_pkg::PSG_VOL_X1, 3'd0, 3'd0, 8'h00, 8'h00,
                                  10'h000);
                default: apply_settings($urandom_range(0, 7) != 0,
                                        2'($urandom_range(0, 3)),
                                        3'($urandom_range(0, 7)),
                                        3'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)),
                                        10'($urandom_range(0, 1023)));
            endcase
            // alternate filling and draining the FIFOs
            push_pct = (phase % 2) ? 35 : 8;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_item(push_pct, 1'b0);
                if (i == PHASE_ITEMS / 2)
                    drain();
            end
            if (phase == 3) begin
                // valid is dropped first so no request repeats while waiting
                drain();
                // keep offering while the result side holds off
                hold_off_req = 1'b1;
                wait (holding);
                repeat (PRESSURE_ITEMS) random_item(push_pct, 1'b1);
            end
            drain();
        end

        if (mismatch_count == 0 && owed_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #500000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
